### rtl/vntc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Value noise terrain classifier package
// Shared beat types, register codes, hash constants and pipeline layout.
// ============================================================================
package vntc_pkg;

    // Input beat: one grid point.
    typedef struct packed {
        logic [15:0] column;
        logic [15:0] row;
    } in_beat_t;

    // Output beat: interpolated noise and its terrain class.
    typedef struct packed {
        logic [15:0] noise_value;
        logic [1:0]  terrain_class;
    } out_beat_t;

    typedef enum logic [1:0] {
        REG_NOISE_SCALE = 2'd0,
        REG_LOW_LIMIT   = 2'd1,
        REG_MID_LIMIT   = 2'd2,
        REG_HIGH_LIMIT  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLASS_WATER = 2'd0,
        CLASS_SAND  = 2'd1,
        CLASS_GRASS = 2'd2,
        CLASS_PEAK  = 2'd3
    } terrain_class_t;

    localparam logic [15:0] NOISE_SCALE_RST = 16'd3277;
    localparam logic [15:0] LOW_LIMIT_RST   = 16'd19661;
    localparam logic [15:0] MID_LIMIT_RST   = 16'd45875;
    localparam logic [15:0] HIGH_LIMIT_RST  = 16'd58982;

    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    // Pipeline stage positions.
    localparam int NUM_STAGES  = 8;
    localparam int ST_SCALE    = 0;
    localparam int ST_CELL     = 1;
    localparam int ST_MIX      = 2;
    localparam int ST_MUL      = 3;
    localparam int ST_CORNER   = 4;
    localparam int ST_ROW      = 5;
    localparam int ST_NOISE    = 6;
    localparam int ST_OUT      = 7;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    function automatic logic [31:0] mix_shift13(input logic [31:0] n);
        return n ^ {{13{n[31]}}, n[31:13]};
    endfunction

    function automatic logic [15:0] corner_bits(input logic [31:0] n);
        logic [31:0] h;
        h = n ^ {{16{n[31]}}, n[31:16]};
        return h[30:15];
    endfunction

endpackage

### rtl/vntc_scale.sv
`timescale 1ns / 1ps
// ============================================================================
// Coordinate scaling stages
// Scales both coordinates, splits off the cell and fraction, and forms the
// first hash products for the cell corner.
// ============================================================================
module vntc_scale #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    aclk,
    input  vntc_pkg::stage_en_t     stage_en,
    input  logic [15:0]             column,
    input  logic [15:0]             row,
    input  logic [15:0]             noise_scale,
    output logic [31:0]             ax,
    output logic [31:0]             by,
    output logic [FRAC_BITS-1:0]    fx,
    output logic [FRAC_BITS-1:0]    fy
);

    localparam logic [15:0] COORD_MASK = (COORD_BITS >= 16) ? 16'hFFFF :
        16'((32'd1 << COORD_BITS) - 32'd1);

    logic [31:0]          px_reg, px_next;
    logic [31:0]          py_reg, py_next;
    logic [31:0]          ax_reg, ax_next;
    logic [31:0]          by_reg, by_next;
    logic [FRAC_BITS-1:0] fx_reg, fx_next;
    logic [FRAC_BITS-1:0] fy_reg, fy_next;
    logic [31:0]          cx;
    logic [31:0]          cy;

    always_comb begin
        px_next = {16'd0, column & COORD_MASK} * {16'd0, noise_scale};
        py_next = {16'd0, row & COORD_MASK} * {16'd0, noise_scale};
        cx      = px_reg >> FRAC_BITS;
        cy      = py_reg >> FRAC_BITS;
        ax_next = cx * vntc_pkg::HASH_MUL_X;
        by_next = cy * vntc_pkg::HASH_MUL_Y;
        fx_next = px_reg[FRAC_BITS-1:0];
        fy_next = py_reg[FRAC_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[vntc_pkg::ST_SCALE]) begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (stage_en[vntc_pkg::ST_CELL]) begin
            ax_reg <= ax_next;
            by_reg <= by_next;
            fx_reg <= fx_next;
            fy_reg <= fy_next;
        end
    end

    assign ax = ax_reg;
    assign by = by_reg;
    assign fx = fx_reg;
    assign fy = fy_reg;

endmodule

### rtl/vntc_hash.sv
`timescale 1ns / 1ps
// ============================================================================
// Corner hash stages
// Finishes the integer hash of all four cell corners and extracts the
// Q0.16 corner values.
// ============================================================================
module vntc_hash #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  vntc_pkg::stage_en_t     stage_en,
    input  logic [31:0]             ax,
    input  logic [31:0]             by,
    input  logic [FRAC_BITS-1:0]    fx_in,
    input  logic [FRAC_BITS-1:0]    fy_in,
    output logic [3:0][15:0]        corner_val,
    output logic [FRAC_BITS-1:0]    fx_out,
    output logic [FRAC_BITS-1:0]    fy_out
);

    // Corner order: 0 is (x, y), 1 is (x+1, y), 2 is (x, y+1), 3 is (x+1, y+1).
    logic [3:0][31:0]     mix_reg, mix_next;
    logic [3:0][31:0]     mul_reg, mul_next;
    logic [3:0][15:0]     val_reg, val_next;
    logic [2:0][FRAC_BITS-1:0] fx_reg;
    logic [2:0][FRAC_BITS-1:0] fy_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mix_next[k] = vntc_pkg::mix_shift13(ax + by
                + ((k % 2 == 1) ? vntc_pkg::HASH_MUL_X : 32'd0)
                + ((k / 2 == 1) ? vntc_pkg::HASH_MUL_Y : 32'd0));
            mul_next[k] = mix_reg[k] * vntc_pkg::HASH_MUL_MIX;
            val_next[k] = vntc_pkg::corner_bits(mul_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[vntc_pkg::ST_MIX]) begin
            mix_reg   <= mix_next;
            fx_reg[0] <= fx_in;
            fy_reg[0] <= fy_in;
        end
        if (stage_en[vntc_pkg::ST_MUL]) begin
            mul_reg   <= mul_next;
            fx_reg[1] <= fx_reg[0];
            fy_reg[1] <= fy_reg[0];
        end
        if (stage_en[vntc_pkg::ST_CORNER]) begin
            val_reg   <= val_next;
            fx_reg[2] <= fx_reg[1];
            fy_reg[2] <= fy_reg[1];
        end
    end

    assign corner_val = val_reg;
    assign fx_out     = fx_reg[2];
    assign fy_out     = fy_reg[2];

endmodule

### rtl/vntc_lerp.sv
`timescale 1ns / 1ps
// ============================================================================
// Bilinear blend stages
// Blends the corner values along x for both rows, then along y.
// ============================================================================
module vntc_lerp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  vntc_pkg::stage_en_t     stage_en,
    input  logic [3:0][15:0]        corner_val,
    input  logic [FRAC_BITS-1:0]    fx,
    input  logic [FRAC_BITS-1:0]    fy,
    output logic [15:0]             noise
);

    localparam int SUM_W = FRAC_BITS + 18;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [15:0]          top_reg, top_next;
    logic [15:0]          bot_reg, bot_next;
    logic [FRAC_BITS-1:0] fy_reg;
    logic [15:0]          noise_reg, noise_next;

    function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                         input logic [FRAC_BITS-1:0] t);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) * SUM_W'(ONE - {1'b0, t}) + SUM_W'(b) * SUM_W'(t);
        return s[FRAC_BITS +: 16];
    endfunction

    always_comb begin
        top_next   = lerp(corner_val[0], corner_val[1], fx);
        bot_next   = lerp(corner_val[2], corner_val[3], fx);
        noise_next = lerp(top_reg, bot_reg, fy_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[vntc_pkg::ST_ROW]) begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            fy_reg  <= fy;
        end
        if (stage_en[vntc_pkg::ST_NOISE]) begin
            noise_reg <= noise_next;
        end
    end

    assign noise = noise_reg;

endmodule

### rtl/value_noise_terrain_classifier_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// Value noise terrain classifier
// An accepted beat passes the scale, cell, mix, mul, corner, row, noise and out stages to m_valid.
// Throughput: one beat per cycle through an eight-register pipeline while m_ready is high.
// Each stage holds under back pressure while bubbles ahead of it still fill.
// Reset clears every stage valid bit and restores the four registers.
// ============================================================================
module value_noise_terrain_classifier_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vntc_pkg::in_beat_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output vntc_pkg::out_beat_t m_payload,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int NST = vntc_pkg::NUM_STAGES;

    logic [15:0] noise_scale_reg, low_limit_reg, mid_limit_reg, high_limit_reg;
    logic        cfg_write;
    vntc_pkg::cfg_reg_t cfg_sel;

    logic [NST-1:0]       valid_reg, valid_next;
    vntc_pkg::stage_en_t  stage_en;

    logic [31:0]          ax, by;
    logic [FRAC_BITS-1:0] fx_cell, fy_cell, fx_corner, fy_corner;
    logic [3:0][15:0]     corner_val;
    logic [15:0]          noise;
    vntc_pkg::terrain_class_t class_next;
    vntc_pkg::out_beat_t  out_reg, out_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = vntc_pkg::cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_scale_reg <= vntc_pkg::NOISE_SCALE_RST;
            low_limit_reg   <= vntc_pkg::LOW_LIMIT_RST;
            mid_limit_reg   <= vntc_pkg::MID_LIMIT_RST;
            high_limit_reg  <= vntc_pkg::HIGH_LIMIT_RST;
        end else if (cfg_write) begin
            case (cfg_sel)
                vntc_pkg::REG_NOISE_SCALE: noise_scale_reg <= pwdata[15:0];
                vntc_pkg::REG_LOW_LIMIT:   low_limit_reg   <= pwdata[15:0];
                vntc_pkg::REG_MID_LIMIT:   mid_limit_reg   <= pwdata[15:0];
                vntc_pkg::REG_HIGH_LIMIT:  high_limit_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            vntc_pkg::REG_NOISE_SCALE: prdata = {16'd0, noise_scale_reg};
            vntc_pkg::REG_LOW_LIMIT:   prdata = {16'd0, low_limit_reg};
            vntc_pkg::REG_MID_LIMIT:   prdata = {16'd0, mid_limit_reg};
            vntc_pkg::REG_HIGH_LIMIT:  prdata = {16'd0, high_limit_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // A stage may load when it is empty or when the stage after it loads.
    always_comb begin
        stage_en[NST-1] = !valid_reg[NST-1] || m_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_next[0] = stage_en[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < NST; i++) begin
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];

    vntc_scale #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_scale (
        .aclk        (aclk),
        .stage_en    (stage_en),
        .column      (s_payload.column),
        .row         (s_payload.row),
        .noise_scale (noise_scale_reg),
        .ax          (ax),
        .by          (by),
        .fx          (fx_cell),
        .fy          (fy_cell)
    );

    vntc_hash #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hash (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .ax         (ax),
        .by         (by),
        .fx_in      (fx_cell),
        .fy_in      (fy_cell),
        .corner_val (corner_val),
        .fx_out     (fx_corner),
        .fy_out     (fy_corner)
    );

    vntc_lerp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .corner_val (corner_val),
        .fx         (fx_corner),
        .fy         (fy_corner),
        .noise      (noise)
    );

    always_comb begin
        if (noise < low_limit_reg) begin
            class_next = vntc_pkg::CLASS_WATER;
        end else if (noise < mid_limit_reg) begin
            class_next = vntc_pkg::CLASS_SAND;
        end else if (noise < high_limit_reg) begin
            class_next = vntc_pkg::CLASS_GRASS;
        end else begin
            class_next = vntc_pkg::CLASS_PEAK;
        end
        out_next.noise_value   = noise;
        out_next.terrain_class = class_next;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[vntc_pkg::ST_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = valid_reg[vntc_pkg::ST_OUT];
    assign m_payload = out_reg;

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while the output side is ready");

    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the output stage is empty");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[vntc_pkg::ST_SCALE])
        else $error("accepted beat did not enter the first stage");

    a_stall_keeps_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[vntc_pkg::ST_CORNER] && !stage_en[vntc_pkg::ST_ROW])
        |=> valid_reg[vntc_pkg::ST_CORNER])
        else $error("stalled stage lost its beat");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Value noise terrain classifier testbench
// Streams grid points through the classifier under several register settings
// and compares every output beat with a bit-exact value noise predictor. Both
// channels idle in random bursts, and the receiver holds off once for a long
// stretch so that the pipeline fills and stalls its input.
// ============================================================================
module tb;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int HOLD_AFTER_BEATS = 200;
    localparam int HOLD_CYCLES      = 80;
    localparam int DRAIN_CYCLES     = 12;

    typedef struct {
        vntc_pkg::in_beat_t  point;
        vntc_pkg::out_beat_t result;
    } terrain_expect_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    vntc_pkg::in_beat_t  s_payload = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    vntc_pkg::out_beat_t m_payload;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [3:0]          paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    logic [15:0] cfg_scale = vntc_pkg::NOISE_SCALE_RST;
    logic [15:0] cfg_low   = vntc_pkg::LOW_LIMIT_RST;
    logic [15:0] cfg_mid   = vntc_pkg::MID_LIMIT_RST;
    logic [15:0] cfg_high  = vntc_pkg::HIGH_LIMIT_RST;

    vntc_pkg::in_beat_t pending_points[$];
    terrain_expect_t    expected_terrain[$];

    int idle_pct            = 0;
    int send_gap            = 0;
    int ready_gap           = 0;
    int hold_left           = 0;
    bit hold_done           = 1'b0;
    int beats_out           = 0;
    int quiet_cycles        = 0;
    int terrain_mismatches  = 0;

    value_noise_terrain_classifier_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] lattice_value(input logic [31:0] cx, input logic [31:0] cy);
        logic [31:0] n;
        logic [31:0] h;
        n = cx * vntc_pkg::HASH_MUL_X + cy * vntc_pkg::HASH_MUL_Y;
        n = (n ^ {{13{n[31]}}, n[31:13]}) * vntc_pkg::HASH_MUL_MIX;
        h = n ^ {{16{n[31]}}, n[31:16]};
        return h[30:15];
    endfunction

    function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] t);
        logic [33:0] acc;
        acc = a * (34'h10000 - t) + b * t;
        return acc[31:16];
    endfunction

    function automatic vntc_pkg::out_beat_t predict_terrain(input vntc_pkg::in_beat_t pt);
        logic [31:0]              px;
        logic [31:0]              py;
        logic [31:0]              cx;
        logic [31:0]              cy;
        logic [15:0]              top;
        logic [15:0]              bottom;
        logic [15:0]              noise;
        vntc_pkg::terrain_class_t cls;
        vntc_pkg::out_beat_t      r;
        px = pt.column * cfg_scale;
        py = pt.row * cfg_scale;
        cx = {16'd0, px[31:16]};
        cy = {16'd0, py[31:16]};
        top    = lerp16(lattice_value(cx, cy), lattice_value(cx + 1, cy), px[15:0]);
        bottom = lerp16(lattice_value(cx, cy + 1), lattice_value(cx + 1, cy + 1), px[15:0]);
        noise  = lerp16(top, bottom, py[15:0]);
        if (noise < cfg_low) begin
            cls = vntc_pkg::CLASS_WATER;
        end else if (noise < cfg_mid) begin
            cls = vntc_pkg::CLASS_SAND;
        end else if (noise < cfg_high) begin
            cls = vntc_pkg::CLASS_GRASS;
        end else begin
            cls = vntc_pkg::CLASS_PEAK;
        end
        r.noise_value   = noise;
        r.terrain_class = cls;
        return r;
    endfunction

    function automatic vntc_pkg::in_beat_t random_point();
        vntc_pkg::in_beat_t pt;
        case ($urandom_range(3))
            0: begin
                pt.column = 16'($urandom_range(255));
                pt.row    = 16'($urandom_range(255));
            end
            1: begin
                pt.column = 16'hFF00 | 16'($urandom_range(255));
                pt.row    = 16'hFF00 | 16'($urandom_range(255));
            end
            default: begin
                pt.column = 16'($urandom_range(16'hFFFF));
                pt.row    = 16'($urandom_range(16'hFFFF));
            end
        endcase
        return pt;
    endfunction

    // Sender: offers the next pending point, with random idle bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_terrain.push_back('{s_payload, predict_terrain(s_payload)});
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_points.size() != 0 && $urandom_range(99) < idle_pct) begin
                    send_gap <= $urandom_range(12, 0);
                    s_valid  <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    s_payload <= pending_points.pop_front();
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each output beat and throttles m_ready.
    always @(posedge aclk) begin
        terrain_expect_t exp_beat;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_out++;
                if (expected_terrain.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, got noise %0d class %0d",
                             $time, m_payload.noise_value, m_payload.terrain_class);
                    terrain_mismatches++;
                end else begin
                    exp_beat = expected_terrain.pop_front();
                    if (m_payload.noise_value !== exp_beat.result.noise_value) begin
                        $display("%0t: noise_value at (%0d,%0d): expected %0d, got %0d",
                                 $time, exp_beat.point.column, exp_beat.point.row,
                                 exp_beat.result.noise_value, m_payload.noise_value);
                        terrain_mismatches++;
                    end
                    if (m_payload.terrain_class !== exp_beat.result.terrain_class) begin
                        $display("%0t: terrain_class at (%0d,%0d): expected %0d, got %0d",
                                 $time, exp_beat.point.column, exp_beat.point.row,
                                 exp_beat.result.terrain_class, m_payload.terrain_class);
                        terrain_mismatches++;
                    end
                end
            end
            if (!hold_done && beats_out >= HOLD_AFTER_BEATS) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (ready_gap != 0) begin
                ready_gap <= ready_gap - 1;
                m_ready   <= 1'b0;
            end else if ($urandom_range(99) < idle_pct) begin
                ready_gap <= $urandom_range(12, 0);
                m_ready   <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_reg(input vntc_pkg::cfg_reg_t idx, input logic [15:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom_range(16'hFFFF)), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            vntc_pkg::REG_NOISE_SCALE: cfg_scale = value;
            vntc_pkg::REG_LOW_LIMIT:   cfg_low   = value;
            vntc_pkg::REG_MID_LIMIT:   cfg_mid   = value;
            vntc_pkg::REG_HIGH_LIMIT:  cfg_high  = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] scale, input logic [15:0] lo,
                             input logic [15:0] mid, input logic [15:0] hi);
        write_reg(vntc_pkg::REG_NOISE_SCALE, scale);
        write_reg(vntc_pkg::REG_LOW_LIMIT, lo);
        write_reg(vntc_pkg::REG_MID_LIMIT, mid);
        write_reg(vntc_pkg::REG_HIGH_LIMIT, hi);
        @(negedge aclk);
    endtask

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++) begin
            pending_points.push_back(random_point());
        end
    endtask

    task automatic drain();
        while (pending_points.size() != 0 || expected_terrain.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] origin_noise;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset register values, corners and alternating bit patterns.
        pending_points.push_back(vntc_pkg::in_beat_t'{16'h0000, 16'h0000});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'hFFFF, 16'hFFFF});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'hFFFF, 16'h0000});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'h0000, 16'hFFFF});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'h8000, 16'h7FFF});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'h0001, 16'h0001});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'hAAAA, 16'h5555});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'h5555, 16'hAAAA});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'h0014, 16'h0013});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'h1234, 16'hFEDC});
        add_random(20);
        drain();

        // Largest scale with all thresholds at zero: everything is at or above the top one.
        idle_pct = 30;
        configure(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        pending_points.push_back(vntc_pkg::in_beat_t'{16'hFFFF, 16'hFFFF});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'h0000, 16'h0000});
        pending_points.push_back(vntc_pkg::in_beat_t'{16'h0001, 16'hFFFE});
        add_random(40);
        drain();

        // Zero scale pins the noise to the origin corner, which lands exactly on
        // the top threshold and then just below it.
        origin_noise = lattice_value(32'd0, 32'd0);
        configure(16'h0000, 16'h0000, 16'h0000, origin_noise);
        add_random(10);
        drain();
        configure(16'h0000, 16'h0000, 16'h0000, origin_noise + 16'd1);
        add_random(10);
        drain();

        // Thresholds out of order: the first comparison that holds decides.
        idle_pct = 50;
        configure(16'd3277, 16'd40000, 16'd20000, 16'd10000);
        add_random(60);
        drain();
        configure(16'd20000, 16'd10000, 16'd60000, 16'd30000);
        add_random(40);
        drain();

        // Smallest nonzero scale; the long receiver hold falls in this stretch.
        idle_pct = 20;
        configure(16'h0001, 16'd16384, 16'd32768, 16'd49152);
        add_random(150);
        drain();

        idle_pct = 40;
        a = 16'($urandom_range(16'hFFFF));
        b = 16'($urandom_range(16'hFFFF));
        c = 16'($urandom_range(16'hFFFF));
        if (a > b) {a, b} = {b, a};
        if (b > c) {b, c} = {c, b};
        if (a > b) {a, b} = {b, a};
        configure(16'($urandom_range(16'hFFFF)), a, b, c);
        add_random(150);
        drain();

        idle_pct = 0;
        configure(vntc_pkg::NOISE_SCALE_RST, vntc_pkg::LOW_LIMIT_RST,
                  vntc_pkg::MID_LIMIT_RST, vntc_pkg::HIGH_LIMIT_RST);
        add_random(150);
        drain();

        if (terrain_mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
rtl/vntc_pkg.sv
rtl/vntc_scale.sv
rtl/vntc_hash.sv
rtl/vntc_lerp.sv
rtl/value_noise_terrain_classifier_unit.sv
tb/tb.sv
